@@ rtl/gpma_pkg.sv @@
package gpma_pkg;

  localparam int unsigned WINDOW_LENGTH_DEF = 5;

  localparam int unsigned NUM_LANES = 2;
  localparam int unsigned LANE_LAT  = 0;
  localparam int unsigned LANE_LON  = 1;

  localparam int unsigned LAT_NMEA_W = 27;
  localparam int unsigned LON_NMEA_W = 28;
  localparam int unsigned V_W        = 28;
  localparam int unsigned DEG_W      = 8;
  localparam int unsigned T_W        = 27;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned Q_W        = 33;
  localparam int unsigned AVG_LAT_W  = 32;
  localparam int unsigned AVG_LON_W  = 33;
  localparam int unsigned FRAC_W     = 30;

  localparam int unsigned RECIP_W   = 21;
  localparam int unsigned RECIP_SH  = 40;
  localparam int unsigned EST_W     = V_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DEG_RECIP = 21'd1099511;

  localparam logic [19:0] DEG_UNIT  = 20'd1000000;
  localparam logic [18:0] DEG_TO_T  = 19'd400000;

  localparam logic [V_W-1:0] VMAX [NUM_LANES] = '{28'd90000000, 28'd180000000};
  localparam logic [T_W-1:0] TMAX [NUM_LANES] = '{27'd54000000, 27'd108000000};

  localparam int unsigned RS_LO_W = 16;
  localparam int unsigned RS_HI_W = 21;
  localparam logic [RS_HI_W+RS_LO_W-1:0] RAD_SCALE = 37'd134148508483;
  localparam logic [RS_LO_W-1:0] RS_LO = RAD_SCALE[RS_LO_W-1:0];
  localparam logic [RS_HI_W-1:0] RS_HI = RAD_SCALE[RS_HI_W+RS_LO_W-1:RS_LO_W];
  localparam int unsigned PLO_W = T_W + RS_LO_W;
  localparam int unsigned MID_W = T_W + RS_HI_W;

  localparam logic signed [Q_W-1:0] MINUS_ONE_RAD = -33'sd1073741824;

  localparam int unsigned DIV_CHUNK_W = 18;

  typedef struct packed {
    logic load;
    logic est;
    logic corr;
    logic tconv;
    logic mlo;
    logic mhi;
    logic upd;
    logic dload;
    logic dstep;
    logic oload;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } stat_t;

endpackage

@@ rtl/gpma_ifs.sv @@
interface gpma_in_if;
  logic        valid;
  logic        ready;
  logic [26:0] lat_nmea;
  logic        lat_is_north;
  logic [27:0] lon_nmea;
  logic        lon_is_east;

  modport source (output valid, lat_nmea, lat_is_north, lon_nmea, lon_is_east,
                  input ready);
  modport sink (input valid, lat_nmea, lat_is_north, lon_nmea, lon_is_east,
                output ready);
endinterface

interface gpma_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] avg_lat;
  logic signed [32:0] avg_lon;

  modport source (output valid, avg_lat, avg_lon, input ready);
  modport sink (input valid, avg_lat, avg_lon, output ready);
endinterface

@@ rtl/gps_position_moving_average_core.sv @@
// Moving average of GPS fixes. Each accepted word carries latitude and
// longitude in NMEA degree-minute form scaled by 10^4 with hemisphere flags;
// inputs above range are clamped, and minutes of 60 or more count as they
// are, with only an angle past the range limit saturating. Both coordinates
// are converted to radians in signed Q2.30 and averaged over the last
// WINDOW_LENGTH fixes, truncated toward zero, and each fix yields one result
// word. After reset the window holds -1 rad in every entry, so early
// averages include those entries. A fix passes in order through a reciprocal
// multiply for the degrees, a correction, the step to ten-thousandths of a
// minute, a two-part multiply by the radian scale, the ring update, the
// magnitude of the running sums, a multiply by the reciprocal of
// WINDOW_LENGTH in 18-bit slices of the sum (two slices for windows of up
// to eight fixes; longer windows need a third slice), and the load of the
// result register; a new fix is accepted only in idle, once the last one
// has been loaded. The result word waits in an output register while the
// next fix is taken; the load of the following result stalls until that
// word has been read.
module gps_position_moving_average_core #(
  parameter int unsigned WINDOW_LENGTH = gpma_pkg::WINDOW_LENGTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  gpma_in_if.sink    in_chan,
  gpma_out_if.source out_chan
);
  import gpma_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gpma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gpma_datapath #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .lat_nmea     (in_chan.lat_nmea),
    .lat_is_north (in_chan.lat_is_north),
    .lon_nmea     (in_chan.lon_nmea),
    .lon_is_east  (in_chan.lon_is_east),
    .avg_lat      (out_chan.avg_lat),
    .avg_lon      (out_chan.avg_lon)
  );

endmodule

@@ rtl/gpma_ctrl.sv @@
module gpma_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  gpma_pkg::stat_t stat,
  output gpma_pkg::cmd_t  cmd
);
  import gpma_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EST   = 4'd1;
  localparam logic [3:0] S_CORR  = 4'd2;
  localparam logic [3:0] S_TCONV = 4'd3;
  localparam logic [3:0] S_MLO   = 4'd4;
  localparam logic [3:0] S_MHI   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_DLOAD = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EST;
        end
      end
      S_EST: begin
        cmd.est   = 1'b1;
        state_nxt = S_CORR;
      end
      S_CORR: begin
        cmd.corr  = 1'b1;
        state_nxt = S_TCONV;
      end
      S_TCONV: begin
        cmd.tconv = 1'b1;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.mlo   = 1'b1;
        state_nxt = S_MHI;
      end
      S_MHI: begin
        cmd.mhi   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.dload = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.oload = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.oload) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("More than one datapath command is active.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.oload |-> (!out_valid_r || out_ready))
    else $error("A pending result word would be overwritten.");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.dstep && !stat.div_last) |=> cmd.dstep)
    else $error("The division stopped before its last step.");

endmodule

@@ rtl/gpma_datapath.sv @@
module gpma_datapath #(
  parameter int unsigned WINDOW_LENGTH = gpma_pkg::WINDOW_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gpma_pkg::cmd_t     cmd,
  output gpma_pkg::stat_t    stat,
  input  logic [26:0]        lat_nmea,
  input  logic               lat_is_north,
  input  logic [27:0]        lon_nmea,
  input  logic               lon_is_east,
  output logic signed [31:0] avg_lat,
  output logic signed [32:0] avg_lon
);
  import gpma_pkg::*;

  localparam int unsigned SLOT_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int unsigned DIV_SH  = $clog2(WINDOW_LENGTH);
  localparam int unsigned TOT_W   = Q_W + DIV_SH;
  localparam int unsigned DIV_CYC = (TOT_W + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
  localparam int unsigned DVD_W   = DIV_CYC * DIV_CHUNK_W;
  localparam int unsigned RCP_W   = DVD_W + 2;
  localparam int unsigned ACC_W   = RCP_W + DIV_CHUNK_W;
  localparam int unsigned CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam logic [RCP_W-1:0] DIV_RECIP =
    RCP_W'(((128'd1 << (DVD_W + DIV_SH)) + 128'(WINDOW_LENGTH) - 128'd1) /
           128'(WINDOW_LENGTH));
  localparam logic signed [TOT_W-1:0] TOT_RST =
    TOT_W'(0) - (TOT_W'(WINDOW_LENGTH) << FRAC_W);

  logic [V_W-1:0]   v_r      [NUM_LANES];
  logic             pos_r    [NUM_LANES];
  logic [DEG_W-1:0] deg_r    [NUM_LANES];
  logic [T_W-1:0]   t_r      [NUM_LANES];
  logic [T_W-1:0]   plo_r    [NUM_LANES];
  logic signed [Q_W-1:0]   new_r [NUM_LANES];
  logic signed [Q_W-1:0]   win_r [NUM_LANES][WINDOW_LENGTH];
  logic signed [TOT_W-1:0] tot_r [NUM_LANES];
  logic [DVD_W-1:0] dq_r     [NUM_LANES];
  logic [RCP_W-1:0] acc_r    [NUM_LANES];
  logic             neg_r    [NUM_LANES];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic signed [AVG_LAT_W-1:0] avg_lat_r;
  logic signed [AVG_LON_W-1:0] avg_lon_r;

  logic [V_W-1:0]   v_raw    [NUM_LANES];
  logic             pos_raw  [NUM_LANES];
  logic [V_W-1:0]   v_nxt    [NUM_LANES];
  logic [DEG_W-1:0] est_nxt  [NUM_LANES];
  logic [DEG_W-1:0] deg_nxt  [NUM_LANES];
  logic [T_W-1:0]   t_nxt    [NUM_LANES];
  logic [T_W-1:0]   plo_nxt  [NUM_LANES];
  logic signed [Q_W-1:0]   new_nxt [NUM_LANES];
  logic signed [TOT_W-1:0] tot_nxt [NUM_LANES];
  logic [DVD_W-1:0] dq_load  [NUM_LANES];
  logic [DVD_W-1:0] dq_nxt   [NUM_LANES];
  logic [RCP_W-1:0] acc_nxt  [NUM_LANES];
  logic [RCP_W-1:0] quot     [NUM_LANES];
  logic [RCP_W-1:0] res      [NUM_LANES];

  assign v_raw[LANE_LAT]   = V_W'(lat_nmea);
  assign v_raw[LANE_LON]   = lon_nmea;
  assign pos_raw[LANE_LAT] = lat_is_north;
  assign pos_raw[LANE_LON] = lon_is_east;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic [EST_W-1:0] p_est;
      logic [V_W-1:0]   whole;
      logic [V_W-1:0]   rem_m;
      logic [V_W-1:0]   t_full;
      logic [PLO_W-1:0] p_lo;
      logic [MID_W-1:0] mid;
      logic [TOT_W-1:0] mag_tot;

      v_nxt[l] = (v_raw[l] > VMAX[l]) ? VMAX[l] : v_raw[l];

      p_est      = EST_W'(v_r[l]) * EST_W'(DEG_RECIP);
      est_nxt[l] = p_est[RECIP_SH+DEG_W-1:RECIP_SH];

      whole      = V_W'(deg_r[l]) * V_W'(DEG_UNIT);
      rem_m      = v_r[l] - whole;
      deg_nxt[l] = (rem_m >= V_W'(DEG_UNIT)) ? deg_r[l] + 1'b1 : deg_r[l];

      t_full   = v_r[l] - V_W'(deg_r[l]) * V_W'(DEG_TO_T);
      t_nxt[l] = (t_full > V_W'(TMAX[l])) ? TMAX[l] : t_full[T_W-1:0];

      p_lo       = PLO_W'(t_r[l]) * PLO_W'(RS_LO);
      plo_nxt[l] = p_lo[PLO_W-1:RS_LO_W];

      mid        = MID_W'(t_r[l]) * MID_W'(RS_HI) + MID_W'(plo_r[l]);
      new_nxt[l] = pos_r[l] ? $signed(Q_W'(mid[MID_W-1:RS_LO_W]))
                            : -$signed(Q_W'(mid[MID_W-1:RS_LO_W]));

      tot_nxt[l] = tot_r[l] + TOT_W'(new_r[l]) - TOT_W'(win_r[l][slot_r]);

      mag_tot    = tot_r[l][TOT_W-1] ? TOT_W'(-tot_r[l]) : TOT_W'(tot_r[l]);
      dq_load[l] = DVD_W'(mag_tot);

      quot[l] = acc_r[l] >> DIV_SH;
      res[l]  = neg_r[l] ? RCP_W'(0) - quot[l] : quot[l];
    end
  end

  // Multiply by the reciprocal of the window length, one slice of the
  // magnitude per cycle, lowest slice first.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic [ACC_W-1:0] sum;
      sum = ACC_W'(acc_r[l]) +
            ACC_W'(dq_r[l][DIV_CHUNK_W-1:0]) * ACC_W'(DIV_RECIP);
      acc_nxt[l] = sum[ACC_W-1:DIV_CHUNK_W];
      dq_nxt[l]  = dq_r[l] >> DIV_CHUNK_W;
    end
  end

  assign slot_nxt = (slot_r == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      cnt_r  <= '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        tot_r[l] <= TOT_RST;
        for (int s = 0; s < WINDOW_LENGTH; s++) begin
          win_r[l][s] <= MINUS_ONE_RAD;
        end
      end
    end else begin
      if (cmd.upd) begin
        slot_r <= slot_nxt;
        for (int l = 0; l < NUM_LANES; l++) begin
          tot_r[l]         <= tot_nxt[l];
          win_r[l][slot_r] <= new_r[l];
        end
      end
      if (cmd.dload) begin
        cnt_r <= '0;
      end else if (cmd.dstep) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (cmd.load) begin
        v_r[l]   <= v_nxt[l];
        pos_r[l] <= pos_raw[l];
      end
      if (cmd.est) begin
        deg_r[l] <= est_nxt[l];
      end
      if (cmd.corr) begin
        deg_r[l] <= deg_nxt[l];
      end
      if (cmd.tconv) begin
        t_r[l] <= t_nxt[l];
      end
      if (cmd.mlo) begin
        plo_r[l] <= plo_nxt[l];
      end
      if (cmd.mhi) begin
        new_r[l] <= new_nxt[l];
      end
      if (cmd.dload) begin
        dq_r[l]  <= dq_load[l];
        acc_r[l] <= '0;
        neg_r[l] <= tot_r[l][TOT_W-1];
      end
      if (cmd.dstep) begin
        dq_r[l]  <= dq_nxt[l];
        acc_r[l] <= acc_nxt[l];
      end
    end
    if (cmd.oload) begin
      avg_lat_r <= $signed(res[LANE_LAT][AVG_LAT_W-1:0]);
      avg_lon_r <= $signed(res[LANE_LON][AVG_LON_W-1:0]);
    end
  end

  assign stat.div_last = (cnt_r == CNT_W'(DIV_CYC - 1));
  assign avg_lat       = avg_lat_r;
  assign avg_lon       = avg_lon_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, slot_r} < (SLOT_W + 1)'(WINDOW_LENGTH)))
    else $error("The write slot left the window.");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.oload |-> ((quot[LANE_LAT] >> (AVG_LAT_W - 1)) == '0 &&
                   (quot[LANE_LON] >> (AVG_LON_W - 1)) == '0))
    else $error("The average does not fit its result field.");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dstep |-> ({1'b0, cnt_r} < (CNT_W + 1)'(DIV_CYC)))
    else $error("The division ran past its last step.");

endmodule
